/* design/sparse_bit_set_decoder_macros.svh */
// assertion helpers, sampled on the rising clock and held off during reset
`ifndef SPARSE_BIT_SET_DECODER_MACROS_SVH
`define SPARSE_BIT_SET_DECODER_MACROS_SVH

// same-cycle implication
`define SBSD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sbsd_pkg.sv */
`default_nettype none

package sbsd_pkg;

  localparam int unsigned MAX_BYTES_DEF  = 1024;
  localparam int unsigned VALUE_BITS_DEF = 24;
  localparam int unsigned BITS_PER_BYTE  = 8;
  localparam int unsigned BIT_IDX_W      = $clog2(BITS_PER_BYTE);
  localparam int unsigned LEN_W          = 11;
  localparam int unsigned MEMBER_W       = 24;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef enum logic [1:0] {
    KIND_MEMBER = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic [LEN_W-1:0]         message_length;
    logic                     first_byte;
  } item_t;

  typedef struct packed {
    kind_e               kind;
    logic [MEMBER_W-1:0] member_value;
    logic                last;
  } result_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic [LEN_W-1:0]         message_length;
    logic                     first_byte;
    logic                     zero_len;
    logic                     too_long;
    logic                     multi_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

/* design/sbsd_front.sv */
`default_nettype none

module sbsd_front
  import sbsd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire item_t         in_data_i,
  input  wire queue_status_t q_stat_i,
  output logic               q_push_o,
  output cmd_t               q_data_o
);

  logic fr_valid_q, fr_valid_d;
  cmd_t fr_q;
  logic accept;

  assign in_stall_o = fr_valid_q & q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = fr_valid_q & ~q_stat_i.full;
  assign q_data_o   = fr_q;

  always_comb begin
    fr_valid_d = accept | (fr_valid_q & ~q_push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  // length checks are settled here so the back end only selects
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_q.data_byte      <= in_data_i.data_byte;
      fr_q.message_length <= in_data_i.message_length;
      fr_q.first_byte     <= in_data_i.first_byte;
      fr_q.zero_len       <= (in_data_i.message_length == '0);
      fr_q.too_long       <= (32'(in_data_i.message_length) > MAX_BYTES);
      fr_q.multi_byte     <= (in_data_i.message_length > LEN_W'(1));
    end
  end

endmodule

`default_nettype wire

/* design/sbsd_queue.sv */
`default_nettype none

module sbsd_queue
  import sbsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire cmd_t    data_i,
  input  wire logic    pop_i,
  output cmd_t         data_o,
  output queue_status_t stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign data_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_d  = push_i ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* design/sbsd_back.sv */
`default_nettype none

module sbsd_back
  import sbsd_pkg::*;
#(
  parameter int unsigned MAX_BYTES  = MAX_BYTES_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire queue_status_t q_stat_i,
  input  wire cmd_t          q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output result_t            out_data_o
);

  localparam int unsigned AW = $clog2(MAX_BYTES);
  localparam int unsigned VW = VALUE_BITS + BIT_IDX_W;

  // byte under work
  cmd_t                     cmd_q;
  logic                     cmd_valid_q, fresh_q;
  logic [BITS_PER_BYTE-1:0] mask_q, n_mask;

  // decode state
  logic [LEN_W-1:0] len_q, pos_q, cnt_q, last_q;
  logic             more_q, err_q;
  logic [LEN_W-1:0] n_len, n_pos, n_cnt, n_last;
  logic             n_more, n_err;

  // base store, read at the next byte position every cycle
  logic [VALUE_BITS-1:0] base_mem [MAX_BYTES];
  logic [VALUE_BITS-1:0] rd_q;
  logic [AW-1:0]         raddr, waddr;

  logic    out_valid_q;
  result_t out_q;

  // effective state: a first byte starts from a fresh set
  logic                  st_first, skip, can_emit, act;
  logic [LEN_W-1:0]      e_len, e_pos, e_cnt, e_last;
  logic                  e_more, e_err;
  logic [VALUE_BITS-1:0] e_base;

  logic [BIT_IDX_W-1:0]     bit_idx;
  logic [BITS_PER_BYTE-1:0] bit_oh, mask_clr;
  logic [VW-1:0]            value;
  logic                     has_bit, ovf, cnt_room, bit_push;
  logic [LEN_W-1:0]         cnt_after, pos_inc, end_v;
  logic                     layer_end, set_done, layer_bad, end_emit;

  logic                emit, push, finish;
  kind_e               emit_kind;
  logic [MEMBER_W-1:0] emit_val;
  logic                emit_last;

  assign can_emit = ~out_valid_q | ~out_stall_i;
  assign st_first = fresh_q & cmd_q.first_byte;
  assign skip     = fresh_q & ~cmd_q.first_byte & (err_q | (pos_q >= len_q));

  assign e_len  = st_first ? cmd_q.message_length : len_q;
  assign e_pos  = st_first ? '0 : pos_q;
  assign e_cnt  = st_first ? LEN_W'(1) : cnt_q;
  assign e_last = st_first ? '0 : last_q;
  assign e_more = st_first ? cmd_q.multi_byte : more_q;
  assign e_err  = st_first ? 1'b0 : err_q;
  // the root byte always has base zero, its entry is never written
  assign e_base = (e_pos == '0) ? '0 : rd_q;

  // lowest set bit first
  always_comb begin
    bit_idx = '0;
    for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        bit_idx = BIT_IDX_W'(i);
      end
    end
  end

  assign has_bit  = (mask_q != '0);
  assign bit_oh   = BITS_PER_BYTE'(1) << bit_idx;
  assign mask_clr = mask_q & ~bit_oh;
  assign value    = {e_base, bit_idx};
  assign ovf      = |e_base[VALUE_BITS-1 -: BIT_IDX_W];
  assign cnt_room = (e_cnt < e_len);
  assign bit_push = has_bit & ~ovf & e_more & cnt_room;

  assign cnt_after = e_cnt + LEN_W'(bit_push);
  assign pos_inc   = e_pos + LEN_W'(1);
  assign end_v     = cnt_after - LEN_W'(1);
  assign layer_end = (pos_inc > e_last);
  assign set_done  = (pos_inc >= e_len);
  assign layer_bad = (end_v >= e_len) | (end_v < pos_inc);
  assign end_emit  = layer_end & (set_done | layer_bad);

  always_comb begin
    n_len     = e_len;
    n_pos     = e_pos;
    n_cnt     = e_cnt;
    n_last    = e_last;
    n_more    = e_more;
    n_err     = e_err;
    n_mask    = mask_q;
    emit      = 1'b0;
    emit_kind = KIND_MEMBER;
    emit_val  = '0;
    emit_last = 1'b0;
    push      = 1'b0;
    finish    = 1'b0;
    if (st_first && cmd_q.zero_len) begin
      emit      = 1'b1;
      emit_kind = KIND_DONE;
      emit_last = 1'b1;
      finish    = 1'b1;
    end else if (st_first && cmd_q.too_long) begin
      emit      = 1'b1;
      emit_kind = KIND_ERROR;
      emit_last = 1'b1;
      n_err     = 1'b1;
      finish    = 1'b1;
    end else if (skip) begin
      finish = 1'b1;
    end else if (has_bit && (ovf || (e_more && !cnt_room))) begin
      // value or base store overflow, rest of the byte is dropped
      emit      = 1'b1;
      emit_kind = KIND_ERROR;
      emit_last = 1'b1;
      n_err     = 1'b1;
      finish    = 1'b1;
    end else begin
      if (has_bit) begin
        n_mask = mask_clr;
        if (e_more) begin
          push  = 1'b1;
          n_cnt = cnt_after;
        end else begin
          emit     = 1'b1;
          emit_val = MEMBER_W'(value);
        end
      end
      // byte end folds into the last bit unless both need a beat
      if (mask_clr == '0 && !(emit && end_emit)) begin
        n_pos  = pos_inc;
        finish = 1'b1;
        if (layer_end) begin
          if (set_done) begin
            emit      = 1'b1;
            emit_kind = KIND_DONE;
            emit_last = 1'b1;
          end else if (layer_bad) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
            emit_last = 1'b1;
            n_err     = 1'b1;
          end else begin
            n_last = end_v;
            n_more = (cnt_after < e_len);
          end
        end
      end
    end
  end

  assign act     = cmd_valid_q & (~emit | can_emit);
  assign q_pop_o = ~q_stat_i.empty & (~cmd_valid_q | (act & finish));

  assign raddr = act ? AW'(n_pos) : AW'(pos_q);
  assign waddr = AW'(e_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
      mask_q      <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      more_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (act) begin
        len_q  <= n_len;
        pos_q  <= n_pos;
        cnt_q  <= n_cnt;
        last_q <= n_last;
        more_q <= n_more;
        err_q  <= n_err;
      end
      if (q_pop_o) begin
        cmd_valid_q <= 1'b1;
        fresh_q     <= 1'b1;
        mask_q      <= q_data_i.data_byte;
      end else begin
        if (act) begin
          mask_q  <= n_mask;
          fresh_q <= 1'b0;
        end
        if (act && finish) begin
          cmd_valid_q <= 1'b0;
        end
      end
      if (act && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
    if (act && emit) begin
      out_q.kind         <= emit_kind;
      out_q.member_value <= emit_val;
      out_q.last         <= emit_last;
    end
  end

  // write-first read so a base pushed in the byte's last cycle is seen next cycle
  always_ff @(posedge clk_i) begin
    if (act && push) begin
      base_mem[waddr] <= value[VALUE_BITS-1:0];
    end
    if (act && push && waddr == raddr) begin
      rd_q <= value[VALUE_BITS-1:0];
    end else begin
      rd_q <= base_mem[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* design/sparse_bit_set_decoder.sv */
// Sparse bit set decoder: turns a layered 8-ary bitmap tree into set members.
// Input channel (in_valid_i, in_stall_o, in_data_i) takes one encoded byte per
// beat; first_byte starts a new set and message_length is sampled with it.
// Output channel (out_valid_o, out_stall_i, out_data_o) gives one result per
// beat: a member, a finished result or an error, the final one with last set.
// A byte passes an input register and a four-entry queue before the decode
// engine, and its results leave through a registered output.
// The engine takes one step per set bit (a push of a base or a member), one
// step on a byte with no set bits or one that is ignored, and one more step
// when a member and the set's closing result come from the same byte. Bases
// live in a MAX_BYTES-deep memory written at the fill count and read at the
// byte position, one port each.
// Reset clears all control state; the base memory is not cleared, each entry
// is written before the set that reads it.
// A stalled receiver holds the output register; the engine keeps pushing
// bases and only waits when it has a result to hand over, and the queue then
// fills until in_stall_o rises.
`default_nettype none
`include "sparse_bit_set_decoder_macros.svh"

module sparse_bit_set_decoder
  import sbsd_pkg::*;
#(
  parameter int unsigned MAX_BYTES  = MAX_BYTES_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output result_t    out_data_o
);

  logic          q_push, q_pop;
  cmd_t          q_in, q_out;
  queue_status_t q_stat;

  sbsd_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_data_o  (q_in)
  );

  sbsd_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_in),
    .pop_i (q_pop),
    .data_o(q_out),
    .stat_o(q_stat)
  );

  sbsd_back #(
    .MAX_BYTES (MAX_BYTES),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_data_i   (q_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  `SBSD_ASSERT(push_when_room, q_push, !q_stat.full, "queue push while full")
  `SBSD_ASSERT(pop_when_filled, q_pop, !q_stat.empty, "queue pop while empty")
  `SBSD_ASSERT_NEXT(push_fills_queue, q_push, !q_stat.empty, "queue empty after a push")
  `SBSD_ASSERT(closing_beat_shape, out_valid_o && out_data_o.kind != KIND_MEMBER,
    out_data_o.last && out_data_o.member_value == '0, "closing result malformed")

endmodule

`default_nettype wire
